// ===== design/hrtp_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package hrtp_pkg;

  localparam int HRTP_SLOTS = 16;
  localparam int HRTP_BINS  = 128;

  // Depth of the result queue and the widths that follow from it.
  localparam int QDEPTH = 4;
  localparam int QPTR_W = $clog2(QDEPTH);
  localparam int QCNT_W = $clog2(QDEPTH + 1);

  localparam logic [30:0] CNT_MAX = 31'h7FFF_FFFF;

  localparam logic [7:0] CH_DASH  = 8'h2D;
  localparam logic [7:0] CH_UNDER = 8'h5F;
  localparam logic [7:0] CH_DOT   = 8'h2E;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_NINE  = 8'h39;

  localparam logic MODE_TEXT   = 1'b0;
  localparam logic MODE_READ   = 1'b1;
  localparam logic KIND_REPORT = 1'b0;
  localparam logic KIND_READ   = 1'b1;

  typedef enum logic [1:0] {
    PH_IDLE = 2'd0,
    PH_ID   = 2'd1,
    PH_CNT  = 2'd2
  } phase_t;

  typedef enum logic [1:0] {
    ST_OK   = 2'd0,
    ST_FEW  = 2'd1,
    ST_MANY = 2'd2,
    ST_OVF  = 2'd3
  } status_t;

  // Request from the parser to the store, built in the accept cycle.
  typedef struct packed {
    logic        go;
    logic        has_res;
    logic        kind;
    logic [3:0]  slot;
    status_t     status;
    logic [7:0]  entries;
    logic        id_zero;
    logic        id_fwd;
    logic        cnt_rd_ok;
    logic        add;
    logic        id_wr;
    logic [30:0] value;
  } hrtp_req_t;

  typedef struct packed {
    logic        kind;
    logic [3:0]  slot;
    logic [30:0] file_id;
    logic [30:0] count;
    logic [7:0]  entries;
    status_t     status;
  } hrtp_word_t;

  // value * 10 + digit, saturating at CNT_MAX.
  function automatic logic [30:0] digit_step(input logic [30:0] v, input logic [3:0] d);
    logic [34:0] w;
    w = 35'({v, 3'b000}) + 35'({v, 1'b0}) + 35'(d);
    if (w > 35'(CNT_MAX)) begin
      return CNT_MAX;
    end
    return w[30:0];
  endfunction

  function automatic logic [30:0] sat_add(input logic [30:0] a, input logic [30:0] b);
    logic [31:0] s;
    s = {1'b0, a} + {1'b0, b};
    if (s[31]) begin
      return CNT_MAX;
    end
    return s[30:0];
  endfunction

endpackage

`default_nettype wire

// ===== design/hrtp_if.sv =====
`timescale 1ns / 1ps
`default_nettype none

interface hrtp_in_if;
  logic       valid;
  logic       ready;
  logic       mode;
  logic [7:0] ch;
  logic       end_of_text;
  logic [3:0] read_slot;
  logic [6:0] read_bin;

  modport source (output valid, mode, ch, end_of_text, read_slot, read_bin, input ready);
  modport sink   (input valid, mode, ch, end_of_text, read_slot, read_bin, output ready);
endinterface

interface hrtp_out_if;
  logic        valid;
  logic        ready;
  logic        kind;
  logic [3:0]  slot;
  logic [30:0] file_id;
  logic [30:0] count;
  logic [7:0]  entries;
  logic [1:0]  status;

  modport source (output valid, kind, slot, file_id, count, entries, status, input ready);
  modport sink   (input valid, kind, slot, file_id, count, entries, status, output ready);
endinterface

`default_nettype wire

// ===== design/hrtp_parser.sv =====
`timescale 1ns / 1ps
`default_nettype none

module hrtp_parser #(
  parameter int SLOTS = hrtp_pkg::HRTP_SLOTS,
  parameter int BINS  = hrtp_pkg::HRTP_BINS
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              acc,
  input  wire logic              mode,
  input  wire logic [7:0]        ch,
  input  wire logic              eot,
  input  wire logic [3:0]        read_slot,
  input  wire logic [6:0]        read_bin,
  output hrtp_pkg::hrtp_req_t    req,
  output logic [((SLOTS > 1) ? $clog2(SLOTS) : 1) + $clog2(BINS) - 1:0] cnt_addr,
  output logic [((SLOTS > 1) ? $clog2(SLOTS) : 1) - 1:0] id_raddr,
  output logic [((SLOTS > 1) ? $clog2(SLOTS) : 1) - 1:0] id_waddr
);
  import hrtp_pkg::*;

  localparam int SLOT_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int BIN_W  = $clog2(BINS);
  localparam int SCNT_W = $clog2(SLOTS + 1);
  localparam int BCNT_W = $clog2(BINS + 1);

  phase_t              phase_r, phase_nxt;
  logic [30:0]         num_r, num_nxt;
  logic [BCNT_W-1:0]   bin_r, bin_nxt;
  logic [SCNT_W-1:0]   slot_r, slot_nxt;
  logic                many_r, many_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_IDLE;
      num_r   <= '0;
      bin_r   <= '0;
      slot_r  <= '0;
      many_r  <= 1'b0;
    end else begin
      phase_r <= phase_nxt;
      num_r   <= num_nxt;
      bin_r   <= bin_nxt;
      slot_r  <= slot_nxt;
      many_r  <= many_nxt;
    end
  end

  always_comb begin
    logic              is_digit, is_dash, is_under, is_dot;
    logic              in_id, in_cnt, under_id, slot_ok;
    logic              commit_a, commit_b, fit_a, fit_b, report;
    logic [30:0]       num_dig, num_after;
    logic [BCNT_W-1:0] b0, b1, b2;
    logic              m0, m1, m2;
    logic              rs_ok, rb_ok;

    is_digit  = (ch >= CH_ZERO) && (ch <= CH_NINE);
    is_dash   = (ch == CH_DASH);
    is_under  = (ch == CH_UNDER);
    is_dot    = (ch == CH_DOT);
    in_id     = (phase_r == PH_ID);
    in_cnt    = (phase_r == PH_CNT);
    under_id  = in_id && is_under;
    slot_ok   = (slot_r < SLOTS);
    num_dig   = digit_step(num_r, ch[3:0]);
    num_after = ((in_id || in_cnt) && is_digit) ? num_dig : num_r;

    // The first commit carries the pending count; a dot or an id's '_' that also
    // ends the text is followed by an empty count, which only moves the counters.
    commit_a = in_cnt && (is_dot || is_dash || eot);
    b0       = under_id ? '0 : bin_r;
    m0       = under_id ? 1'b0 : many_r;
    fit_a    = (b0 < BINS);
    b1       = (commit_a && fit_a) ? b0 + BCNT_W'(1) : b0;
    m1       = m0 | (commit_a && !fit_a);
    commit_b = eot && ((in_cnt && is_dot) || under_id);
    fit_b    = (b1 < BINS);
    b2       = (commit_b && fit_b) ? b1 + BCNT_W'(1) : b1;
    m2       = m1 | (commit_b && !fit_b);
    report   = (in_cnt && is_dash) || (eot && ((in_cnt && !is_dash) || under_id));

    rs_ok = (read_slot < SLOTS);
    rb_ok = (read_bin < BINS);

    req.go        = acc;
    req.value     = in_cnt ? num_after : num_r;
    req.add       = 1'b0;
    req.id_wr     = 1'b0;
    req.id_fwd    = 1'b0;
    if (mode == MODE_READ) begin
      req.has_res   = 1'b1;
      req.kind      = KIND_READ;
      req.slot      = read_slot;
      req.status    = ST_OK;
      req.entries   = '0;
      req.id_zero   = !rs_ok;
      req.cnt_rd_ok = rs_ok && rb_ok;
      id_raddr      = SLOT_W'(read_slot);
      cnt_addr      = {SLOT_W'(read_slot), BIN_W'(read_bin)};
    end else begin
      req.has_res   = report;
      req.kind      = KIND_REPORT;
      req.slot      = slot_ok ? 4'(slot_r) : '0;
      req.entries   = 8'(b2);
      req.id_zero   = !slot_ok;
      req.id_fwd    = under_id;
      req.cnt_rd_ok = 1'b0;
      req.add       = commit_a && fit_a && slot_ok;
      req.id_wr     = under_id && slot_ok;
      if (!slot_ok) begin
        req.status = ST_OVF;
      end else if (m2) begin
        req.status = ST_MANY;
      end else if (b2 < BINS) begin
        req.status = ST_FEW;
      end else begin
        req.status = ST_OK;
      end
      id_raddr = SLOT_W'(slot_r);
      cnt_addr = {SLOT_W'(slot_r), BIN_W'(b0)};
    end
    id_waddr = SLOT_W'(slot_r);

    phase_nxt = phase_r;
    num_nxt   = num_r;
    bin_nxt   = bin_r;
    slot_nxt  = slot_r;
    many_nxt  = many_r;
    if (acc && (mode == MODE_TEXT)) begin
      if (eot) begin
        phase_nxt = PH_IDLE;
        num_nxt   = '0;
        bin_nxt   = '0;
        slot_nxt  = '0;
        many_nxt  = 1'b0;
      end else begin
        unique case (phase_r)
          PH_IDLE: begin
            if (is_dash) begin
              phase_nxt = PH_ID;
              num_nxt   = '0;
            end
          end
          PH_ID: begin
            if (is_digit) begin
              num_nxt = num_dig;
            end else if (is_dash) begin
              num_nxt = '0;
            end else if (is_under) begin
              num_nxt   = '0;
              bin_nxt   = '0;
              many_nxt  = 1'b0;
              phase_nxt = PH_CNT;
            end
          end
          PH_CNT: begin
            if (is_digit) begin
              num_nxt = num_dig;
            end else if (is_dot) begin
              num_nxt  = '0;
              bin_nxt  = b1;
              many_nxt = m1;
            end else if (is_dash) begin
              num_nxt   = '0;
              bin_nxt   = b1;
              many_nxt  = m1;
              phase_nxt = PH_ID;
              if (slot_ok) begin
                slot_nxt = slot_r + SCNT_W'(1);
              end
            end
          end
          default: begin
            phase_nxt = PH_IDLE;
          end
        endcase
      end
    end
  end

endmodule

`default_nettype wire

// ===== design/hrtp_store.sv =====
`timescale 1ns / 1ps
`default_nettype none

module hrtp_store #(
  parameter int SLOTS = hrtp_pkg::HRTP_SLOTS,
  parameter int BINS  = hrtp_pkg::HRTP_BINS
) (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire hrtp_pkg::hrtp_req_t req,
  input  wire logic [((SLOTS > 1) ? $clog2(SLOTS) : 1) + $clog2(BINS) - 1:0] cnt_addr,
  input  wire logic [((SLOTS > 1) ? $clog2(SLOTS) : 1) - 1:0] id_raddr,
  input  wire logic [((SLOTS > 1) ? $clog2(SLOTS) : 1) - 1:0] id_waddr,
  output logic                     clearing,
  output logic                     busy,
  output logic                     push,
  output hrtp_pkg::hrtp_word_t     word
);
  import hrtp_pkg::*;

  localparam int SLOT_W    = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int BIN_W     = $clog2(BINS);
  localparam int ADDR_W    = SLOT_W + BIN_W;
  localparam int CNT_DEPTH = 1 << ADDR_W;
  localparam int ID_DEPTH  = 1 << SLOT_W;

  logic [30:0] cnt_mem [CNT_DEPTH];
  logic [30:0] id_mem  [ID_DEPTH];

  logic              clr_r;
  logic [ADDR_W-1:0] clr_cnt_r;
  logic              s1_go_r;
  hrtp_req_t         s1_req_r;
  logic [ADDR_W-1:0] s1_addr_r;
  logic [30:0]       cnt_rdata_r, id_rdata_r, fwd_data_r;
  logic              fwd_hit_r;

  logic              cnt_we, id_we;
  logic [ADDR_W-1:0] cnt_waddr;
  logic [SLOT_W-1:0] id_wa;
  logic [30:0]       cnt_wdata, id_wdata, base, sum;

  // Sweep every entry of both memories once after reset.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_r     <= 1'b1;
      clr_cnt_r <= '0;
    end else if (clr_r) begin
      clr_cnt_r <= clr_cnt_r + ADDR_W'(1);
      if (clr_cnt_r == ADDR_W'(CNT_DEPTH - 1)) begin
        clr_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_go_r <= 1'b0;
    end else begin
      s1_go_r <= req.go;
    end
  end

  always_ff @(posedge clk) begin
    s1_req_r   <= req;
    s1_addr_r  <= cnt_addr;
    fwd_hit_r  <= s1_go_r && s1_req_r.add && (s1_addr_r == cnt_addr);
    fwd_data_r <= sum;
  end

  // The counter read of an item may race the write-back of the item before it.
  assign base = fwd_hit_r ? fwd_data_r : cnt_rdata_r;
  assign sum  = sat_add(base, s1_req_r.value);

  assign cnt_we    = clr_r || (s1_go_r && s1_req_r.add);
  assign cnt_waddr = clr_r ? clr_cnt_r : s1_addr_r;
  assign cnt_wdata = clr_r ? '0 : sum;

  assign id_we    = (clr_r && (clr_cnt_r[ADDR_W-1:SLOT_W] == '0)) || (req.go && req.id_wr);
  assign id_wa    = clr_r ? clr_cnt_r[SLOT_W-1:0] : id_waddr;
  assign id_wdata = clr_r ? '0 : req.value;

  always_ff @(posedge clk) begin
    if (cnt_we) begin
      cnt_mem[cnt_waddr] <= cnt_wdata;
    end
    cnt_rdata_r <= cnt_mem[cnt_addr];
  end

  always_ff @(posedge clk) begin
    if (id_we) begin
      id_mem[id_wa] <= id_wdata;
    end
    id_rdata_r <= id_mem[id_raddr];
  end

  always_comb begin
    word.kind    = s1_req_r.kind;
    word.slot    = s1_req_r.slot;
    word.entries = s1_req_r.entries;
    word.status  = s1_req_r.status;
    if (s1_req_r.id_zero) begin
      word.file_id = '0;
    end else if (s1_req_r.id_fwd) begin
      word.file_id = s1_req_r.value;
    end else begin
      word.file_id = id_rdata_r;
    end
    word.count = ((s1_req_r.kind == KIND_READ) && s1_req_r.cnt_rd_ok) ? base : '0;
  end

  assign push     = s1_go_r && s1_req_r.has_res;
  assign busy     = s1_go_r;
  assign clearing = clr_r;

endmodule

`default_nettype wire

// ===== design/hrtp_out_queue.sv =====
`timescale 1ns / 1ps
`default_nettype none

module hrtp_out_queue (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 push,
  input  wire hrtp_pkg::hrtp_word_t word,
  input  wire logic                 busy,
  output logic                      room,
  output logic [hrtp_pkg::QCNT_W-1:0] count,
  hrtp_out_if.source                out_if
);
  import hrtp_pkg::*;

  hrtp_word_t        q_mem [QDEPTH];
  logic [QPTR_W-1:0] wr_ptr_r, rd_ptr_r;
  logic [QCNT_W-1:0] cnt_r;
  logic              pop;
  hrtp_word_t        head;

  assign pop = out_if.valid && out_if.ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= wr_ptr_r + QPTR_W'(1);
      end
      if (pop) begin
        rd_ptr_r <= rd_ptr_r + QPTR_W'(1);
      end
      cnt_r <= cnt_r + QCNT_W'(push) - QCNT_W'(pop);
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      q_mem[wr_ptr_r] <= word;
    end
  end

  // A new word may enter only if its result is sure to find a free entry.
  assign room  = (cnt_r + QCNT_W'(busy)) < QCNT_W'(QDEPTH);
  assign count = cnt_r;
  assign head  = q_mem[rd_ptr_r];

  assign out_if.valid   = (cnt_r != '0);
  assign out_if.kind    = head.kind;
  assign out_if.slot    = head.slot;
  assign out_if.file_id = head.file_id;
  assign out_if.count   = head.count;
  assign out_if.entries = head.entries;
  assign out_if.status  = head.status;

endmodule

`default_nettype wire

// ===== design/histogram_record_text_parser_unit.sv =====
`timescale 1ns / 1ps
`default_nettype none

// Histogram record text parser. Text enters one character per word (mode 0); records of the
// form '-' id '_' count '.' count ... are parsed, each id is kept per slot and each count is
// added, saturating at 2^31-1, into a slot-by-bin counter memory. When a record closes on '-'
// or on the word flagged end_of_text, one report word gives slot, id, number of counts and a
// status (ok, too few, too many, slot overflow); a final count without a trailing '.' is
// counted too. A mode 1 word reads one stored counter and the id of its slot. The block
// takes one word per clock while in_if.ready is high: each word does at most one
// read-modify-write of the counter memory, read in the accept cycle and written back in the
// next, so its result is pushed into the output queue in the cycle after acceptance. A
// counter read right behind a write to the same entry gets the new value by forwarding.
// After reset the block sweeps both memories to zero, one entry per clock, over all
// 2**(slot index bits + bin index bits) counter addresses (2048 at the default sizes);
// in_if.ready stays low until the sweep is done. Results wait in a four-word queue,
// so input keeps flowing while the output side stalls for a short time.
module histogram_record_text_parser_unit #(
  parameter int SLOTS = hrtp_pkg::HRTP_SLOTS,
  parameter int BINS  = hrtp_pkg::HRTP_BINS
) (
  input  wire logic  clk,
  input  wire logic  rst_n,
  hrtp_in_if.sink    in_if,
  hrtp_out_if.source out_if
);
  import hrtp_pkg::*;

  localparam int SLOT_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int BIN_W  = $clog2(BINS);

  logic                    acc;
  logic                    clearing;
  logic                    busy;
  logic                    push;
  logic                    room;
  logic [QCNT_W-1:0]       q_count;
  hrtp_req_t               req;
  hrtp_word_t              word;
  logic [SLOT_W+BIN_W-1:0] cnt_addr;
  logic [SLOT_W-1:0]       id_raddr;
  logic [SLOT_W-1:0]       id_waddr;

  // Input is held off during the clearing sweep and whenever the queue
  // could not take the result of another word.
  assign in_if.ready = !clearing && room;
  assign acc         = in_if.valid && in_if.ready;

  // Parser state and the decode of each word into one memory request.
  hrtp_parser #(
    .SLOTS(SLOTS),
    .BINS (BINS)
  ) u_parser (
    .clk      (clk),
    .rst_n    (rst_n),
    .acc      (acc),
    .mode     (in_if.mode),
    .ch       (in_if.ch),
    .eot      (in_if.end_of_text),
    .read_slot(in_if.read_slot),
    .read_bin (in_if.read_bin),
    .req      (req),
    .cnt_addr (cnt_addr),
    .id_raddr (id_raddr),
    .id_waddr (id_waddr)
  );

  // Counter and id memories with the write-back stage.
  hrtp_store #(
    .SLOTS(SLOTS),
    .BINS (BINS)
  ) u_store (
    .clk     (clk),
    .rst_n   (rst_n),
    .req     (req),
    .cnt_addr(cnt_addr),
    .id_raddr(id_raddr),
    .id_waddr(id_waddr),
    .clearing(clearing),
    .busy    (busy),
    .push    (push),
    .word    (word)
  );

  hrtp_out_queue u_queue (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (push),
    .word  (word),
    .busy  (busy),
    .room  (room),
    .count (q_count),
    .out_if(out_if)
  );

`ifndef NO_ASSERTIONS
  // A result must always find a free queue entry.
  assert property (@(posedge clk) disable iff (!rst_n)
    push |-> ((q_count < QCNT_W'(QDEPTH)) || (out_if.valid && out_if.ready)))
    else $error("result queue overflow");

  // Nothing can be delivered while the memories are still being cleared.
  assert property (@(posedge clk) disable iff (!rst_n)
    clearing |-> !out_if.valid)
    else $error("output word during clearing sweep");

  // Every result comes from the word accepted in the cycle before.
  assert property (@(posedge clk) disable iff (!rst_n)
    push |-> $past(in_if.valid && in_if.ready))
    else $error("result without an accepted word");
`endif

endmodule

`default_nettype wire

// ===== dv/histogram_record_text_parser_unit_test.sv =====
`timescale 1ns / 1ps

// Self-checking bench for the histogram record text parser. Text and read words are queued
// up front, then fed through the input channel in bursts. Every accepted word runs through a
// local copy of the parser, and whatever result that word should produce is queued. Each word
// that leaves the output channel is compared field by field with the oldest queued result.
module histogram_record_text_parser_unit_test;
  import hrtp_pkg::*;

  // The block sweeps its memories after reset, and the receiver now and then holds ready low
  // for a long stretch. Nothing legal leaves both channels quiet for as long as this limit.
  localparam int STUCK_LIMIT = 10000;
  localparam int HOLD_CYCLES = 300;
  localparam int WORD_TARGET = 1950;

  // Stall patterns of the result receiver.
  localparam int RX_FREE   = 0;
  localparam int RX_LIGHT  = 1;
  localparam int RX_THIRD  = 2;
  localparam int RX_HEAVY  = 3;

  typedef struct packed {
    logic       mode;
    logic [7:0] ch;
    logic       eot;
    logic [3:0] rs;
    logic [6:0] rb;
  } char_word_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  hrtp_in_if  in_if ();
  hrtp_out_if out_if ();

  histogram_record_text_parser_unit i_dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_if  (in_if),
    .out_if (out_if)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Words waiting to be sent, and results that the parser copy says are still owed.
  char_word_t text_words [$];
  hrtp_word_t due_words [$];
  int         errors = 0;

  // Parser copy. These mirror the block's registers and both of its memories.
  phase_t      scan_phase;
  logic [30:0] number;
  int          bins_done;
  int          rec_slot;
  bit          overfull;
  logic [30:0] id_tab [HRTP_SLOTS];
  logic [30:0] hist [HRTP_SLOTS][HRTP_BINS];

  // Clamp a sum or a decimal step to the largest value a 31-bit counter can hold.
  function automatic logic [30:0] clip_sum(input longint s);
    return (s > longint'(CNT_MAX)) ? CNT_MAX : s[30:0];
  endfunction

  // A count is added into the current bin only while the record still has room for it;
  // beyond that the record is just marked as having too many counts.
  function automatic void commit_count();
    if (bins_done < HRTP_BINS) begin
      if (rec_slot < HRTP_SLOTS) begin
        hist[rec_slot][bins_done] =
          clip_sum(longint'(hist[rec_slot][bins_done]) + longint'(number));
      end
      bins_done++;
    end else begin
      overfull = 1'b1;
    end
    number = '0;
  endfunction

  // Closing a record commits the pending count first, so a count with no trailing dot still
  // lands in the table. A record past the last slot reports slot 0 and id 0.
  function automatic hrtp_word_t close_record();
    hrtp_word_t r;
    commit_count();
    r = '0;
    r.kind = KIND_REPORT;
    if (rec_slot >= HRTP_SLOTS) begin
      r.status = ST_OVF;
    end else if (overfull) begin
      r.status = ST_MANY;
    end else if (bins_done < HRTP_BINS) begin
      r.status = ST_FEW;
    end else begin
      r.status = ST_OK;
    end
    r.entries = 8'(bins_done);
    if (rec_slot < HRTP_SLOTS) begin
      r.slot = 4'(rec_slot);
      r.file_id = id_tab[rec_slot];
      rec_slot++;
    end
    return r;
  endfunction

  // Runs one accepted word through the parser copy. Returns 1 when the word owes a result.
  function automatic bit parse_word(input char_word_t w, output hrtp_word_t r);
    bit   got;
    logic is_digit;
    got = 1'b0;
    r = '0;
    // A read never disturbs the parser, even when its end-of-text bit is set.
    if (w.mode == MODE_READ) begin
      r.kind = KIND_READ;
      r.slot = w.rs;
      r.file_id = id_tab[w.rs];
      r.count = hist[w.rs][w.rb];
      return 1'b1;
    end
    is_digit = (w.ch >= CH_ZERO) && (w.ch <= CH_NINE);
    case (scan_phase)
      PH_IDLE: begin
        if (w.ch == CH_DASH) begin
          scan_phase = PH_ID;
          number = '0;
        end
      end
      PH_ID: begin
        if (is_digit) begin
          number = clip_sum(longint'(number) * 10 + longint'(w.ch - CH_ZERO));
        end else if (w.ch == CH_DASH) begin
          number = '0;
        end else if (w.ch == CH_UNDER) begin
          if (rec_slot < HRTP_SLOTS) begin
            id_tab[rec_slot] = number;
          end
          number = '0;
          bins_done = 0;
          overfull = 1'b0;
          scan_phase = PH_CNT;
        end
      end
      default: begin
        if (is_digit) begin
          number = clip_sum(longint'(number) * 10 + longint'(w.ch - CH_ZERO));
        end else if (w.ch == CH_DOT) begin
          commit_count();
        end else if (w.ch == CH_DASH) begin
          r = close_record();
          got = 1'b1;
          scan_phase = PH_ID;
          number = '0;
        end
      end
    endcase
    // End of text closes an open record unless a dash on this same word already did, and
    // always drops the parser back to slot 0 so the next text adds into the same slots.
    if (w.eot) begin
      if (scan_phase == PH_CNT && !got) begin
        r = close_record();
        got = 1'b1;
      end
      scan_phase = PH_IDLE;
      number = '0;
      bins_done = 0;
      overfull = 1'b0;
      rec_slot = 0;
    end
    return got;
  endfunction

  // ---------------------------------------------------------------------------------------
  // Stimulus builders. Fields that a word does not use still get random values.
  // ---------------------------------------------------------------------------------------
  task automatic put_plain(input logic [7:0] c);
    char_word_t w;
    w.mode = MODE_TEXT;
    w.ch = c;
    w.eot = 1'b0;
    w.rs = 4'($urandom_range(0, 15));
    w.rb = 7'($urandom_range(0, 127));
    text_words.push_back(w);
  endtask

  task automatic put_read(input logic [3:0] rs, input logic [6:0] rb);
    char_word_t w;
    w.mode = MODE_READ;
    w.ch = 8'($urandom_range(0, 255));
    w.eot = 1'($urandom_range(0, 1));
    w.rs = rs;
    w.rb = rb;
    text_words.push_back(w);
  endtask

  task automatic put_string(input string s);
    for (int i = 0; i < s.len(); i++) begin
      put_plain(s[i]);
    end
  endtask

  // Sets end-of-text on the newest queued word, which is always a text character here.
  task automatic mark_end();
    char_word_t w;
    w = text_words.pop_back();
    w.eot = 1'b1;
    text_words.push_back(w);
  endtask

  // A character of a well-formed record, now and then preceded by a read, often of a low slot
  // or bin, or by a byte that the parser skips.
  task automatic put_ch(input logic [7:0] c);
    logic [7:0] junk;
    if ($urandom_range(0, 11) == 0) begin
      put_read(4'($urandom_range(0, 1) ? $urandom_range(0, 15) : $urandom_range(0, 3)),
               7'($urandom_range(0, 1) ? $urandom_range(0, 127) : $urandom_range(0, 7)));
    end
    if ($urandom_range(0, 39) == 0) begin
      do begin
        junk = 8'($urandom_range(0, 255));
      end while ((junk >= CH_ZERO && junk <= CH_NINE) ||
                 junk == CH_DASH || junk == CH_UNDER || junk == CH_DOT);
      put_plain(junk);
    end
    put_plain(c);
  endtask

  task automatic put_digits(input string s);
    for (int i = 0; i < s.len(); i++) begin
      put_ch(s[i]);
    end
  endtask

  // Counts are mostly small, sometimes empty, sometimes large enough that a few of them
  // saturate a counter, and sometimes too long to fit at all.
  task automatic put_count();
    int pick;
    pick = $urandom_range(0, 29);
    if (pick < 4) begin
      return;
    end else if (pick == 4) begin
      put_digits("99999999999");
    end else if (pick < 8) begin
      put_digits($sformatf("%0d", $urandom_range(0, 32'h7FFF_FFFF)));
    end else begin
      put_digits($sformatf("%0d", $urandom_range(0, 99)));
    end
  endtask

  task automatic put_record(input int nc);
    int pick;
    put_ch(CH_DASH);
    pick = $urandom_range(0, 19);
    if (pick == 1) begin
      put_digits("99999999999");
    end else if (pick < 5 && pick != 0) begin
      put_digits($sformatf("%0d", $urandom_range(0, 32'h7FFF_FFFF)));
    end else if (pick != 0) begin
      put_digits($sformatf("%0d", $urandom_range(0, 999)));
    end
    put_ch(CH_UNDER);
    for (int i = 0; i < nc; i++) begin
      if (i > 0) begin
        put_ch(CH_DOT);
      end
      put_count();
    end
  endtask

  // One text: a run of records, or a long one near the bin limit, or so many short ones
  // that slots run out, or plain noise. Its last character carries end-of-text, which may
  // land on a count, a trailing dot, a dash or an unfinished id.
  task automatic put_text();
    int kind;
    int tail;
    kind = $urandom_range(0, 11);
    if (kind == 0) begin
      for (int i = $urandom_range(HRTP_SLOTS + 1, HRTP_SLOTS + 4); i > 0; i--) begin
        put_record($urandom_range(0, 2));
      end
    end else if (kind < 3) begin
      put_record($urandom_range(HRTP_BINS - 1, HRTP_BINS + 2));
    end else if (kind == 3) begin
      for (int i = $urandom_range(10, 30); i > 0; i--) begin
        put_plain(8'($urandom_range(0, 255)));
        if ($urandom_range(0, 9) == 0) begin
          mark_end();
        end
      end
    end else begin
      for (int i = $urandom_range(1, 4); i > 0; i--) begin
        put_record(($urandom_range(0, 3) == 0) ? $urandom_range(9, 24) : $urandom_range(0, 8));
      end
    end
    tail = $urandom_range(0, 5);
    if (kind != 3) begin
      if (tail == 0) begin
        put_ch(CH_DOT);
      end else if (tail == 1) begin
        put_ch(CH_DASH);
      end else if (tail == 2) begin
        put_ch(CH_DASH);
        put_digits($sformatf("%0d", $urandom_range(0, 999)));
      end
    end
    mark_end();
  endtask

  // ---------------------------------------------------------------------------------------
  // Driver. Words go out in bursts of random length with random gaps, some of them zero.
  // The word on the bus is predicted at the edge where the block takes it.
  // ---------------------------------------------------------------------------------------
  char_word_t sent_word;
  char_word_t next_word;
  hrtp_word_t owed;
  int         burst_left = 0;
  int         gap_left = 0;

  always @(posedge clk) begin
    if (!rst_n) begin
      in_if.valid <= 1'b0;
    end else begin
      if (in_if.valid && in_if.ready) begin
        if (parse_word(sent_word, owed)) begin
          due_words.push_back(owed);
        end
      end
      if (!in_if.valid || in_if.ready) begin
        if (gap_left > 0) begin
          gap_left--;
          in_if.valid <= 1'b0;
        end else if (text_words.size() != 0) begin
          next_word = text_words.pop_front();
          sent_word = next_word;
          in_if.valid <= 1'b1;
          in_if.mode <= next_word.mode;
          in_if.ch <= next_word.ch;
          in_if.end_of_text <= next_word.eot;
          in_if.read_slot <= next_word.rs;
          in_if.read_bin <= next_word.rb;
          if (burst_left > 0) begin
            burst_left--;
          end else begin
            burst_left = $urandom_range(1, 40);
            gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
          end
        end else begin
          in_if.valid <= 1'b0;
        end
      end
    end
  end

  // ---------------------------------------------------------------------------------------
  // Receiver and checker. Ready follows a stall pattern that changes now and then at random.
  // Twice in the run it holds ready low for a long stretch while the driver keeps offering,
  // so the four-word result queue fills and the block has to stall its input.
  // ---------------------------------------------------------------------------------------
  hrtp_word_t want;
  int         seen_words = 0;
  int         holds_done = 0;
  int         hold_left = 0;
  int         rx_pattern = RX_FREE;
  int         pattern_left = 0;
  int         rx_tick = 0;

  task automatic check_field(input string name, input logic [30:0] exp_v,
                             input logic [30:0] act_v);
    if (exp_v !== act_v) begin
      $display("%0t: result field %s mismatch, expected %0d, actual %0d",
               $time, name, exp_v, act_v);
      errors++;
    end
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      out_if.ready <= 1'b0;
    end else begin
      if (out_if.valid && out_if.ready) begin
        seen_words++;
        if (due_words.size() == 0) begin
          $display("%0t: unexpected result word, expected none, actual kind %0d slot %0d",
                   $time, out_if.kind, out_if.slot);
          errors++;
        end else begin
          want = due_words.pop_front();
          check_field("kind", 31'(want.kind), 31'(out_if.kind));
          check_field("slot", 31'(want.slot), 31'(out_if.slot));
          check_field("file_id", want.file_id, out_if.file_id);
          check_field("count", want.count, out_if.count);
          check_field("entries", 31'(want.entries), 31'(out_if.entries));
          check_field("status", 31'(want.status), 31'(out_if.status));
        end
      end
      rx_tick++;
      if (pattern_left == 0) begin
        rx_pattern = $urandom_range(RX_FREE, RX_HEAVY);
        pattern_left = $urandom_range(20, 80);
      end else begin
        pattern_left--;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_if.ready <= 1'b0;
      end else if (holds_done < 2 && seen_words >= (holds_done + 1) * 80) begin
        hold_left = HOLD_CYCLES - 1;
        holds_done++;
        out_if.ready <= 1'b0;
      end else begin
        case (rx_pattern)
          RX_FREE:  out_if.ready <= 1'b1;
          RX_LIGHT: out_if.ready <= ($urandom_range(0, 3) != 0);
          RX_THIRD: out_if.ready <= (rx_tick % 3 == 0);
          default:  out_if.ready <= ($urandom_range(0, 3) == 0);
        endcase
      end
    end
  end

  // Watchdog: a run where neither channel moves a word for too long has hung.
  int stuck_cycles = 0;

  always @(posedge clk) begin
    if ((in_if.valid && in_if.ready) || (out_if.valid && out_if.ready)) begin
      stuck_cycles = 0;
    end else begin
      stuck_cycles++;
    end
    if (stuck_cycles >= STUCK_LIMIT) begin
      $display("status: fail");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------------------
  // Main sequence: fill the word queue, release reset, wait until every owed result is in.
  // ---------------------------------------------------------------------------------------
  initial begin
    in_if.valid = 1'b0;
    in_if.mode = MODE_TEXT;
    in_if.ch = '0;
    in_if.end_of_text = 1'b0;
    in_if.read_slot = '0;
    in_if.read_bin = '0;
    out_if.ready = 1'b0;

    scan_phase = PH_IDLE;
    number = '0;
    bins_done = 0;
    rec_slot = 0;
    overfull = 1'b0;
    for (int s = 0; s < HRTP_SLOTS; s++) begin
      id_tab[s] = '0;
      for (int b = 0; b < HRTP_BINS; b++) begin
        hist[s][b] = '0;
      end
    end

    // Directed opening: a read of the cleared store at its last corner, bytes at both ends of
    // the range while idle, an id restarted by a second dash, an id and a count that both
    // saturate, a record closed by a dash, and a final count with no trailing dot that is
    // closed by end of text.
    put_read(4'd15, 7'd127);
    put_plain(8'h00);
    put_plain(8'hFF);
    put_string("-7-9999999999_9999999999.4-");
    put_string("5_1");
    mark_end();
    put_read(4'd0, 7'd0);
    put_read(4'd1, 7'd0);

    // A record with exactly the full number of counts and one with too many, then random
    // texts until the word budget is used up.
    put_record(HRTP_BINS);
    mark_end();
    put_record(HRTP_BINS + 2);
    mark_end();
    while (text_words.size() < WORD_TARGET) begin
      put_text();
    end

    repeat (5) @(posedge clk);
    rst_n <= 1'b1;

    while (text_words.size() != 0 || in_if.valid) begin
      @(posedge clk);
    end
    while (due_words.size() != 0) begin
      @(posedge clk);
    end
    // Waiting on past the last owed result catches any stray extra result.
    repeat (10) @(posedge clk);

    if (errors == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
